[hw/rtl/isf_pkg.sv]
package isf_pkg;

  localparam int unsigned CntW = 40;
  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  localparam logic [1:0] OpClear = 2'd0;
  localparam logic [1:0] OpLoad  = 2'd1;
  localparam logic [1:0] OpTest  = 2'd2;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StOrder = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  chrom_id;
    logic [31:0] position;
    logic [31:0] end_position;
  } in_item_t;

  typedef struct packed {
    logic            selected;
    logic [1:0]      status;
    logic [10:0]     interval_count;
    logic [CntW-1:0] sites_total;
    logic [CntW-1:0] sites_selected;
  } out_item_t;

  // Outcome of one interval load.
  typedef struct packed {
    status_e     status;
    logic        merge;
    logic        append;
    logic        new_chrom;
    logic [31:0] merged_stop;
  } load_dec_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CntMax) ? v : v + CntW'(1);
  endfunction

endpackage

[hw/rtl/interval_site_filter_top.sv]
// Channel | Direction | Handshake                  | Beat
// in      | input     | in_valid_i / in_ready_o    | isf_pkg::in_item_t
// out     | output    | out_valid_o / out_ready_i  | isf_pkg::out_item_t
//
// Clear, load and no-op items finish in the execute state, where the result register loads
// once free. A site test runs execute, scan and compare, ending in scan if the range is empty; a
// chromosome change adds a lookup of the chromosome's entry range, and each skipped entry adds a
// compare step, as the single read port of the interval memory is stepped one entry a cycle.
// Reset leaves the table empty at once; no clearing pass is needed.
// A waiting result does not block acceptance, but the next item holds its final
// step until the result register is free.
module interval_site_filter_top #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned CHROM_COUNT = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  isf_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output isf_pkg::out_item_t out_data_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ChromSlots = 64;
  localparam logic [10:0] ChromLimit = 11'(CHROM_COUNT);
  localparam logic [CW-1:0] DepthVal = CW'(TABLE_DEPTH);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SExec = 3'd1;
  localparam logic [2:0] SChrd = 3'd2;
  localparam logic [2:0] SScan = 3'd3;
  localparam logic [2:0] SCmp  = 3'd4;

  logic [2:0] state_q, state_d;
  isf_pkg::in_item_t  in_q;
  isf_pkg::out_item_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic [CW-1:0] count_q, count_d;
  logic last_valid_q, last_valid_d;
  logic [5:0] last_chrom_q, last_chrom_d;
  logic [31:0] last_start_q, last_start_d;
  logic [31:0] last_stop_q, last_stop_d;
  logic [CW-1:0] last_first_q, last_first_d;
  logic [ChromSlots-1:0] present_q, present_d;
  logic site_valid_q, site_valid_d;
  logic [5:0] site_chrom_q, site_chrom_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] lim_q, lim_d;
  logic [isf_pkg::CntW-1:0] total_q, total_d;
  logic [isf_pkg::CntW-1:0] sel_q, sel_d;

  // Interval entries: start in the upper half, stop in the lower half.
  logic [63:0] ent_mem [TABLE_DEPTH];
  logic [63:0] ent_rd_q;
  logic ent_we, ent_re;
  logic [IW-1:0] ent_waddr, ent_raddr;
  logic [63:0] ent_wdata;

  // Per chromosome: first entry in the upper half, end entry in the lower half.
  logic [2*CW-1:0] chr_mem [ChromSlots];
  logic [2*CW-1:0] chr_rd_q;
  logic chr_we, chr_re;
  logic [5:0] chr_waddr;
  logic [2*CW-1:0] chr_wdata;

  logic can_out, fin, fin_sel;
  isf_pkg::status_e fin_status;
  logic chrom_ok;
  logic [CW-1:0] ptr_nx;
  isf_pkg::load_dec_t dec;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign can_out     = !out_valid_q || out_ready_i;
  assign chrom_ok    = ({5'b0, in_q.chrom_id} < ChromLimit);
  assign ptr_nx      = ptr_q + CW'(1);

  isf_merge u_merge (
    .chrom_ok_i   (chrom_ok),
    .present_i    (present_q[in_q.chrom_id]),
    .last_valid_i (last_valid_q),
    .chrom_i      (in_q.chrom_id),
    .last_chrom_i (last_chrom_q),
    .count_nz_i   (count_q != '0),
    .full_i       (count_q == DepthVal),
    .start_i      (in_q.position),
    .stop_i       (in_q.end_position),
    .last_start_i (last_start_q),
    .last_stop_i  (last_stop_q),
    .dec_o        (dec)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    last_valid_d = last_valid_q;
    last_chrom_d = last_chrom_q;
    last_start_d = last_start_q;
    last_stop_d  = last_stop_q;
    last_first_d = last_first_q;
    present_d    = present_q;
    site_valid_d = site_valid_q;
    site_chrom_d = site_chrom_q;
    ptr_d        = ptr_q;
    lim_d        = lim_q;
    total_d      = total_q;
    sel_d        = sel_q;
    ent_we       = 1'b0;
    ent_waddr    = count_q[IW-1:0];
    ent_wdata    = {in_q.position, in_q.end_position};
    ent_re       = 1'b0;
    ent_raddr    = ptr_q[IW-1:0];
    chr_we       = 1'b0;
    chr_waddr    = in_q.chrom_id;
    chr_wdata    = {count_q, count_q + CW'(1)};
    chr_re       = 1'b0;
    fin          = 1'b0;
    fin_sel      = 1'b0;
    fin_status   = isf_pkg::StOk;

    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          state_d = SExec;
        end
      end
      SExec: begin
        case (in_q.opcode)
          isf_pkg::OpClear: begin
            if (can_out) begin
              fin          = 1'b1;
              count_d      = '0;
              last_valid_d = 1'b0;
              present_d    = '0;
              site_valid_d = 1'b0;
              ptr_d        = '0;
              lim_d        = '0;
              total_d      = '0;
              sel_d        = '0;
            end
          end
          isf_pkg::OpLoad: begin
            if (can_out) begin
              fin        = 1'b1;
              fin_status = dec.status;
              if (dec.merge) begin
                last_stop_d = dec.merged_stop;
                ent_we      = 1'b1;
                ent_waddr   = IW'(count_q - CW'(1));
                ent_wdata   = {last_start_q, dec.merged_stop};
              end else if (dec.append) begin
                ent_we       = 1'b1;
                last_start_d = in_q.position;
                last_stop_d  = in_q.end_position;
                count_d      = count_q + CW'(1);
                chr_we       = 1'b1;
                if (dec.new_chrom) begin
                  present_d[in_q.chrom_id] = 1'b1;
                  last_first_d = count_q;
                  last_chrom_d = in_q.chrom_id;
                  last_valid_d = 1'b1;
                end else begin
                  chr_waddr = last_chrom_q;
                  chr_wdata = {last_first_q, count_q + CW'(1)};
                end
              end
            end
          end
          isf_pkg::OpTest: begin
            state_d = SScan;
            if (!site_valid_q || in_q.chrom_id != site_chrom_q) begin
              site_valid_d = 1'b1;
              site_chrom_d = in_q.chrom_id;
              if (chrom_ok && present_q[in_q.chrom_id]) begin
                chr_re  = 1'b1;
                state_d = SChrd;
              end else begin
                ptr_d = '0;
                lim_d = '0;
              end
            end
          end
          default: begin
            fin = can_out;
          end
        endcase
        if (fin) begin
          state_d = SIdle;
        end
      end
      SChrd: begin
        ptr_d   = chr_rd_q[2*CW-1:CW];
        lim_d   = chr_rd_q[CW-1:0];
        state_d = SScan;
      end
      SScan: begin
        if (ptr_q < lim_q) begin
          ent_re  = 1'b1;
          state_d = SCmp;
        end else if (can_out) begin
          fin     = 1'b1;
          total_d = isf_pkg::sat_inc(total_q);
          state_d = SIdle;
        end
      end
      SCmp: begin
        if (ent_rd_q[31:0] <= in_q.position) begin
          // Entry ends at or before the site: step past it.
          ptr_d = ptr_nx;
          if (ptr_nx < lim_q) begin
            ent_re    = 1'b1;
            ent_raddr = ptr_nx[IW-1:0];
          end else begin
            state_d = SScan;
          end
        end else if (can_out) begin
          fin     = 1'b1;
          fin_sel = (ent_rd_q[63:32] <= in_q.position);
          total_d = isf_pkg::sat_inc(total_q);
          if (fin_sel) begin
            sel_d = isf_pkg::sat_inc(sel_q);
          end
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase

    out_d                = out_q;
    out_d.selected       = fin_sel;
    out_d.status         = fin_status;
    out_d.interval_count = 11'(count_d);
    out_d.sites_total    = total_d;
    out_d.sites_selected = sel_d;
    if (fin) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      out_valid_q  <= 1'b0;
      count_q      <= '0;
      last_valid_q <= 1'b0;
      present_q    <= '0;
      site_valid_q <= 1'b0;
      ptr_q        <= '0;
      lim_q        <= '0;
      total_q      <= '0;
      sel_q        <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      count_q      <= count_d;
      last_valid_q <= last_valid_d;
      present_q    <= present_d;
      site_valid_q <= site_valid_d;
      ptr_q        <= ptr_d;
      lim_q        <= lim_d;
      total_q      <= total_d;
      sel_q        <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (fin) begin
      out_q <= out_d;
    end
    last_chrom_q <= last_chrom_d;
    last_start_q <= last_start_d;
    last_stop_q  <= last_stop_d;
    last_first_q <= last_first_d;
    site_chrom_q <= site_chrom_d;
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rd_q <= ent_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (chr_we) begin
      chr_mem[chr_waddr] <= chr_wdata;
    end
    if (chr_re) begin
      chr_rd_q <= chr_mem[in_q.chrom_id];
    end
  end

endmodule

[hw/rtl/isf_merge.sv]
module isf_merge (
  input  logic                  chrom_ok_i,
  input  logic                  present_i,
  input  logic                  last_valid_i,
  input  logic [5:0]            chrom_i,
  input  logic [5:0]            last_chrom_i,
  input  logic                  count_nz_i,
  input  logic                  full_i,
  input  logic [31:0]           start_i,
  input  logic [31:0]           stop_i,
  input  logic [31:0]           last_start_i,
  input  logic [31:0]           last_stop_i,
  output isf_pkg::load_dec_t    dec_o
);

  logic same_chrom;

  assign same_chrom = last_valid_i && (chrom_i == last_chrom_i) && count_nz_i;

  always_comb begin
    dec_o             = '0;
    dec_o.status      = isf_pkg::StOk;
    dec_o.merged_stop = (stop_i > last_stop_i) ? stop_i : last_stop_i;
    if (!chrom_ok_i) begin
      dec_o.status = isf_pkg::StOrder;
    end else if (same_chrom) begin
      if (start_i < last_start_i) begin
        dec_o.status = isf_pkg::StOrder;
      end else if (start_i <= last_stop_i) begin
        // Touching or overlapping the last entry: widen it in place.
        dec_o.merge = 1'b1;
      end else if (full_i) begin
        dec_o.status = isf_pkg::StFull;
      end else begin
        dec_o.append = 1'b1;
      end
    end else if (present_i) begin
      // This chromosome already has entries and has been left behind.
      dec_o.status = isf_pkg::StOrder;
    end else if (full_i) begin
      dec_o.status = isf_pkg::StFull;
    end else begin
      dec_o.append    = 1'b1;
      dec_o.new_chrom = 1'b1;
    end
  end

endmodule

[tb/interval_site_filter_top_tb.sv]
`timescale 1ns / 100ps

module interval_site_filter_top_tb;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned ChromCount = 64;
  localparam logic [1:0]  OpNop      = 2'd3;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned TailCycles = 64;

  class isf_scoreboard;
    logic [31:0]              ivl_lo [TableDepth];
    logic [31:0]              ivl_hi [TableDepth];
    int unsigned              chrom_head [ChromCount];
    int unsigned              chrom_tail [ChromCount];
    bit                       chrom_seen [ChromCount];
    int unsigned              n_entries;
    bit                       load_chrom_ok;
    logic [5:0]               load_chrom;
    bit                       site_chrom_ok;
    logic [5:0]               site_chrom;
    int unsigned              scan_ptr;
    int unsigned              scan_end;
    logic [isf_pkg::CntW-1:0] n_tested;
    logic [isf_pkg::CntW-1:0] n_selected;
    isf_pkg::out_item_t       pending_results [$];
    int unsigned              n_checked;
    int unsigned              n_mismatch;
    int unsigned              n_full;
    int unsigned              n_order;
    int unsigned              n_hits;

    function new();
      clear_table();
    endfunction

    function void clear_table();
      foreach (chrom_seen[i]) chrom_seen[i] = 1'b0;
      n_entries     = 0;
      load_chrom_ok = 1'b0;
      load_chrom    = '0;
      site_chrom_ok = 1'b0;
      site_chrom    = '0;
      scan_ptr      = 0;
      scan_end      = 0;
      n_tested      = '0;
      n_selected    = '0;
    endfunction

    function void append_entry(logic [31:0] lo, logic [31:0] hi);
      ivl_lo[n_entries] = lo;
      ivl_hi[n_entries] = hi;
      n_entries++;
    endfunction

    function isf_pkg::status_e load_interval(logic [5:0] c, logic [31:0] lo,
                                             logic [31:0] hi);
      int unsigned last;
      if (load_chrom_ok && c == load_chrom && n_entries > 0) begin
        last = n_entries - 1;
        if (lo < ivl_lo[last]) return isf_pkg::StOrder;
        // Touching or overlapping the last entry: widen it, no new entry needed.
        if (lo <= ivl_hi[last]) begin
          if (hi > ivl_hi[last]) ivl_hi[last] = hi;
          return isf_pkg::StOk;
        end
        if (n_entries >= TableDepth) return isf_pkg::StFull;
        append_entry(lo, hi);
        chrom_tail[c] = n_entries;
        return isf_pkg::StOk;
      end
      if (chrom_seen[c]) return isf_pkg::StOrder;
      if (n_entries >= TableDepth) return isf_pkg::StFull;
      chrom_head[c] = n_entries;
      append_entry(lo, hi);
      chrom_tail[c] = n_entries;
      chrom_seen[c] = 1'b1;
      load_chrom_ok = 1'b1;
      load_chrom    = c;
      return isf_pkg::StOk;
    endfunction

    function logic test_site(logic [5:0] c, logic [31:0] pos);
      logic hit = 1'b0;
      if (n_tested != isf_pkg::CntMax) n_tested++;
      if (!site_chrom_ok || c != site_chrom) begin
        site_chrom_ok = 1'b1;
        site_chrom    = c;
        scan_ptr      = chrom_seen[c] ? chrom_head[c] : 0;
        scan_end      = chrom_seen[c] ? chrom_tail[c] : 0;
      end
      while (scan_ptr < scan_end && ivl_hi[scan_ptr] <= pos) scan_ptr++;
      if (scan_ptr < scan_end && ivl_lo[scan_ptr] <= pos && pos < ivl_hi[scan_ptr])
        hit = 1'b1;
      if (hit && n_selected != isf_pkg::CntMax) n_selected++;
      return hit;
    endfunction

    function isf_pkg::out_item_t filter_step(isf_pkg::in_item_t it);
      isf_pkg::out_item_t r = '0;
      case (it.opcode)
        isf_pkg::OpClear: clear_table();
        isf_pkg::OpLoad:  r.status = load_interval(it.chrom_id, it.position, it.end_position);
        isf_pkg::OpTest:  r.selected = test_site(it.chrom_id, it.position);
        default: ;
      endcase
      r.interval_count = 11'(n_entries);
      r.sites_total    = n_tested;
      r.sites_selected = n_selected;
      return r;
    endfunction

    function void note_item(isf_pkg::in_item_t it);
      isf_pkg::out_item_t r;
      r = filter_step(it);
      if (r.status == isf_pkg::StFull) n_full++;
      if (r.status == isf_pkg::StOrder) n_order++;
      if (r.selected) n_hits++;
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void check_result(isf_pkg::out_item_t got);
      isf_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: unexpected result beat sel=%0d st=%0d cnt=%0d tot=%0d hits=%0d",
                   $time, got.selected, got.status, got.interval_count, got.sites_total,
                   got.sites_selected);
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      if (got.selected !== want.selected || got.status !== want.status ||
          got.interval_count !== want.interval_count ||
          got.sites_total !== want.sites_total ||
          got.sites_selected !== want.sites_selected) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("%0t: result %0d expected sel=%0d st=%0d cnt=%0d tot=%0d hits=%0d",
                   $time, n_checked, want.selected, want.status, want.interval_count,
                   want.sites_total, want.sites_selected);
          $display("%0t: result %0d actual   sel=%0d st=%0d cnt=%0d tot=%0d hits=%0d",
                   $time, n_checked, got.selected, got.status, got.interval_count,
                   got.sites_total, got.sites_selected);
        end
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  isf_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  isf_pkg::out_item_t out_data_o;

  isf_scoreboard scb = new();
  int unsigned   src_idle_pct = 0;
  int unsigned   sink_stall_pct = 0;
  int unsigned   n_sent = 0;
  int unsigned   quiet_cycles = 0;

  interval_site_filter_top u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result side: check the beat taken at this edge, then pick next cycle's ready.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) scb.check_result(out_data_o);
    out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic isf_pkg::in_item_t make_item(logic [1:0] op, logic [5:0] c,
                                                  logic [31:0] p, logic [31:0] e);
    isf_pkg::in_item_t it;
    it.opcode       = op;
    it.chrom_id     = c;
    it.position     = p;
    it.end_position = e;
    return it;
  endfunction

  // Valid is left high after a beat is taken; the next call decides whether it drops.
  task automatic send_item(input isf_pkg::in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    scb.note_item(it);
    n_sent++;
  endtask

  // One clear, sorted interval loads chromosome by chromosome, then sorted site sweeps,
  // with a sprinkling of broken and unrelated beats in both halves.
  task automatic run_session(input int unsigned n_chroms, input int unsigned max_loads,
                             input int unsigned min_loads, input int unsigned min_step);
    logic [5:0]      order [64];
    logic [5:0]      tmp;
    logic [5:0]      c;
    longint unsigned base [64];
    longint unsigned top [64];
    longint unsigned cur;
    longint unsigned start;
    longint unsigned stop;
    longint unsigned site;
    longint unsigned step_max;
    int unsigned     pick;
    int unsigned     n;
    int unsigned     want;
    int unsigned     j;
    for (int i = 0; i < 64; i++) order[i] = 6'(i);
    for (int i = 63; i > 0; i--) begin
      j = $urandom_range(i, 0);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    send_item(make_item(isf_pkg::OpClear, 6'($urandom), $urandom, $urandom));
    for (int i = 0; i < n_chroms; i++) begin
      c = order[i];
      cur = $urandom_range(32'hF000_0000, 0);
      base[i] = cur;
      top[i] = cur;
      n = $urandom_range(max_loads, min_loads);
      for (int k = 0; k < n; k++) begin
        pick = $urandom_range(99);
        if (pick < 4 && cur >= 64) begin
          send_item(make_item(isf_pkg::OpLoad, c, 32'(cur - $urandom_range(63, 1)),
                              32'(cur + 10)));
        end else if (pick < 8 && i > 0) begin
          // Loads onto a chromosome that is already closed.
          send_item(make_item(isf_pkg::OpLoad, order[$urandom_range(i - 1, 0)], $urandom,
                              $urandom));
        end else if (pick < 10) begin
          send_item(make_item(OpNop, 6'($urandom), $urandom, $urandom));
        end else if (pick < 12) begin
          send_item(make_item(isf_pkg::OpTest, c, 32'(cur), $urandom));
        end else begin
          start = cur + (($urandom_range(9) == 0) ? 0 : $urandom_range(200, min_step));
          if (pick >= 96 && start >= 20) stop = start - $urandom_range(20, 1);
          else stop = start + $urandom_range(120, 0);
          send_item(make_item(isf_pkg::OpLoad, c, 32'(start), 32'(stop)));
          cur = start;
          if (stop > top[i]) top[i] = stop;
        end
      end
    end
    for (int i = 0; i <= n_chroms; i++) begin
      if (i == n_chroms) begin
        c = order[$urandom_range(63, n_chroms)];
        repeat ($urandom_range(3, 1))
          send_item(make_item(isf_pkg::OpTest, c, $urandom, $urandom));
      end else if ($urandom_range(4) != 0) begin
        c = order[i];
        want = $urandom_range(24, 4);
        step_max = (top[i] - base[i]) * 2 / want + 1;
        site = (base[i] >= 60) ? base[i] - 60 : 0;
        n = 0;
        while (site <= top[i] + 60 && n < 2 * want + 4) begin
          pick = $urandom_range(99);
          if (pick < 4) begin
            send_item(make_item(isf_pkg::OpTest, c,
                                32'(site) - 32'($urandom_range(200, 1)), $urandom));
          end else if (pick < 7) begin
            send_item(make_item(isf_pkg::OpTest, 6'($urandom), $urandom, $urandom));
          end else if (pick < 9) begin
            send_item(make_item(OpNop, 6'($urandom), $urandom, $urandom));
          end else if (pick < 11) begin
            // Late load on the last loaded chromosome, seen only after a chromosome change.
            start = top[n_chroms - 1] + $urandom_range(300, 0);
            send_item(make_item(isf_pkg::OpLoad, order[n_chroms - 1], 32'(start),
                                32'(start + $urandom_range(100, 0))));
          end else begin
            send_item(make_item(isf_pkg::OpTest, c, 32'(site), $urandom));
            site += $urandom_range(step_max, 0);
          end
          n++;
        end
      end
    end
  endtask

  initial begin
    int unsigned n_directed;
    int unsigned sess;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(make_item(isf_pkg::OpTest, 6'd0, 32'd0, 32'hFFFF_FFFF));
    send_item(make_item(OpNop, 6'd63, 32'hFFFF_FFFF, 32'd0));
    send_item(make_item(isf_pkg::OpLoad, 6'd0, 32'd10, 32'd20));
    send_item(make_item(isf_pkg::OpLoad, 6'd0, 32'd20, 32'd30));
    send_item(make_item(isf_pkg::OpLoad, 6'd0, 32'd15, 32'd25));
    send_item(make_item(isf_pkg::OpLoad, 6'd0, 32'd5, 32'd8));
    send_item(make_item(isf_pkg::OpLoad, 6'd0, 32'd40, 32'd40));
    send_item(make_item(isf_pkg::OpLoad, 6'd0, 32'd50, 32'd45));
    send_item(make_item(isf_pkg::OpLoad, 6'd0, 32'd60, 32'hFFFF_FFFF));
    send_item(make_item(isf_pkg::OpLoad, 6'd63, 32'd0, 32'd100));
    send_item(make_item(isf_pkg::OpLoad, 6'd0, 32'd70, 32'd80));
    send_item(make_item(isf_pkg::OpTest, 6'd0, 32'd9, 32'd0));
    send_item(make_item(isf_pkg::OpTest, 6'd0, 32'd10, 32'd0));
    send_item(make_item(isf_pkg::OpTest, 6'd0, 32'd40, 32'd0));
    send_item(make_item(isf_pkg::OpTest, 6'd0, 32'd12, 32'd0));
    send_item(make_item(isf_pkg::OpTest, 6'd0, 32'hFFFF_FFFE, 32'd0));
    send_item(make_item(isf_pkg::OpTest, 6'd63, 32'd99, 32'd0));
    send_item(make_item(isf_pkg::OpTest, 6'd5, 32'd3, 32'd0));
    send_item(make_item(isf_pkg::OpLoad, 6'd10, 32'd0, 32'd5));
    send_item(make_item(isf_pkg::OpTest, 6'd10, 32'd4, 32'd0));
    send_item(make_item(isf_pkg::OpLoad, 6'd10, 32'd3, 32'd9));
    send_item(make_item(isf_pkg::OpTest, 6'd10, 32'd7, 32'd0));
    send_item(make_item(isf_pkg::OpLoad, 6'd10, 32'd20, 32'd30));
    send_item(make_item(isf_pkg::OpTest, 6'd10, 32'd25, 32'd0));
    send_item(make_item(isf_pkg::OpTest, 6'd63, 32'd0, 32'd0));
    send_item(make_item(isf_pkg::OpTest, 6'd10, 32'd25, 32'd0));
    send_item(make_item(isf_pkg::OpClear, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(make_item(isf_pkg::OpTest, 6'd0, 32'd10, 32'd0));
    n_directed = n_sent;

    // Small sessions rotate through the four idling phases.
    sess = 0;
    while (n_sent < n_directed + 900 || sess < 4) begin
      case (sess % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
        default: begin src_idle_pct = 9; sink_stall_pct = 9; end
      endcase
      run_session($urandom_range(8, 1), 12, 1, 0);
      sess++;
    end
    in_valid_i <= 1'b0;

    while (scb.pending_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d beats in %0d sessions; %0d results checked, %0d sites selected.",
             n_sent, sess, scb.n_checked, scb.n_hits);
    $display("Loads refused: %0d with the table full, %0d out of order.",
             scb.n_full, scb.n_order);
    if (scb.n_mismatch == 0 && scb.pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
